// ===== hdl/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants of the prime field arithmetic unit.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int OPCODE_W = 3;
  localparam int FIELD_W  = 32;

  localparam logic [OPCODE_W-1:0] OP_ADD = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SUB = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_MUL = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DIV = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_POW = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_EQ  = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_NE  = 3'd6;

  // modulus after reset, cut to the configured width at the top level
  localparam logic [63:0] RESET_PRIME = 64'd2147483647;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [FIELD_W-1:0]        operand_a;
    logic [FIELD_W-1:0]        operand_b;
    logic signed [FIELD_W-1:0] exponent;
  } cmd_t;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               range_error;
  } res_t;

endpackage

// ===== hdl/pfa_modmul.sv =====
// ----------------------------------------------------------------------------
// pfa_modmul
// Bit-serial modular multiplier: double-and-add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pfa_modmul #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(WIDTH - 1);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] xr;
  logic [WIDTH-1:0] yr;
  logic [WIDTH-1:0] mr;
  logic [WIDTH+1:0] m1x;
  logic [WIDTH+1:0] m2x;
  logic [WIDTH+1:0] t;
  logic [WIDTH+1:0] t_red;

  assign m1x = (WIDTH+2)'(mr);
  assign m2x = {1'b0, mr, 1'b0};
  // 2*acc + bit*x stays below 3m, so at most 2m comes off
  assign t   = {1'b0, product, 1'b0} + (yr[WIDTH-1] ? (WIDTH+2)'(xr) : '0);

  always_comb begin
    if (t >= m2x) begin
      t_red = t - m2x;
    end else if (t >= m1x) begin
      t_red = t - m1x;
    end else begin
      t_red = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        product <= '0;
        xr      <= x;
        yr      <= y;
        mr      <= m;
        cnt     <= CNT_TOP;
        active  <= 1'b1;
      end else if (active) begin
        product <= t_red[WIDTH-1:0];
        yr      <= yr << 1;
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/pfa_expred.sv =====
// ----------------------------------------------------------------------------
// pfa_expred
// Reduces a negative exponent to its least residue modulo p-1,
// shift-subtract remainder one magnitude bit per cycle.
// ----------------------------------------------------------------------------
module pfa_expred #(
  parameter int WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pfa_pkg::FIELD_W-1:0]   mag,
  input  logic [WIDTH-1:0]              m1,
  output logic                          done,
  output logic [((WIDTH > 32) ? WIDTH : 32)-1:0] exp_out
);

  import pfa_pkg::*;

  localparam int XW    = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;
  localparam int CNT_W = $clog2(FIELD_W);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(FIELD_W - 1);

  logic               active;
  logic [CNT_W-1:0]   cnt;
  logic [FIELD_W-1:0] mag_r;
  logic [WIDTH-1:0]   m1_r;
  logic [WIDTH-1:0]   rem;
  logic [WIDTH:0]     t;

  assign t = {rem, mag_r[FIELD_W-1]};

  // (m1 - mag % m1) % m1; a zero m1 gives zero
  assign exp_out = (m1_r == '0 || rem == '0) ? '0 : XW'(m1_r - rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mag_r  <= mag;
        m1_r   <= m1;
        rem    <= '0;
        cnt    <= CNT_TOP;
        active <= 1'b1;
      end else if (active) begin
        if (t >= {1'b0, m1_r}) begin
          rem <= WIDTH'(t - {1'b0, m1_r});
        end else begin
          rem <= t[WIDTH-1:0];
        end
        mag_r <= mag_r << 1;
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/prime_field_alu.sv =====
// ----------------------------------------------------------------------------
// prime_field_alu
// Modular add, subtract, multiply, divide, power and compare over a
// configurable prime, built around a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// A command transfers on a rising edge with start high and busy low; its
// result shows on result for exactly one cycle with result_valid high and
// cannot be held off. Add, subtract, compare, unused opcodes, range errors
// and divide by zero finish at once: the result is registered at the transfer
// edge and busy stays low. Every modular product runs through one shared
// multiplier. Power walks max(WIDTH,32) exponent bits, one squaring per bit
// plus one product per set bit; a negative exponent is first reduced modulo
// p-1 in the serial remainder unit. Divide is a power by p-2 followed by one
// more product. The user must write the modulus through cfg_we/cfg_data only
// while busy is low; the block itself does not enforce this.
module prime_field_alu #(
  parameter int WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pfa_pkg::cmd_t   cmd,
  output logic            busy,
  input  logic            cfg_we,
  input  logic [WIDTH-1:0] cfg_data,
  output logic            result_valid,
  output pfa_pkg::res_t   result
);

  import pfa_pkg::*;

  localparam int XW    = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;
  localparam int CNT_W = $clog2(XW);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(XW - 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RED   = 5'b00010,
    S_SQ    = 5'b00100,
    S_MULB  = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  state_t              state;
  logic [WIDTH-1:0]    prime;
  logic [OPCODE_W-1:0] op_r;
  logic [WIDTH-1:0]    a_r;
  logic [WIDTH-1:0]    b_r;
  logic [WIDTH-1:0]    base_r;
  logic [WIDTH-1:0]    acc;
  logic [XW-1:0]       exp_r;
  logic [CNT_W-1:0]    bitcnt;

  logic [WIDTH-1:0]    a_in;
  logic [WIDTH-1:0]    b_in;
  logic                a_bad;
  logic                b_bad;
  logic [WIDTH:0]      sum;
  logic [WIDTH-1:0]    add_v;
  logic [WIDTH-1:0]    sub_v;
  logic [WIDTH-1:0]    acc_one;
  logic                imm;
  res_t                imm_res;
  logic                go_mul;
  logic                go_red;
  logic [XW-1:0]       launch_exp;
  logic [FIELD_W-1:0]  mag;

  logic                mul_start;
  logic [WIDTH-1:0]    mul_x;
  logic [WIDTH-1:0]    mul_y;
  logic                mul_done;
  logic [WIDTH-1:0]    mul_p;
  logic                red_go;
  logic                red_done;
  logic [XW-1:0]       red_e;
  logic                adv;

  assign busy = (state != S_IDLE);

  assign a_in  = WIDTH'(cmd.operand_a);
  assign b_in  = WIDTH'(cmd.operand_b);
  assign a_bad = XW'(cmd.operand_a) >= XW'(prime);
  assign b_bad = XW'(cmd.operand_b) >= XW'(prime);
  assign sum   = (WIDTH+1)'(a_in) + (WIDTH+1)'(b_in);
  assign add_v = (sum >= (WIDTH+1)'(prime)) ? WIDTH'(sum - (WIDTH+1)'(prime)) : WIDTH'(sum);
  // wraps into p - (b - a) when b > a
  assign sub_v = (a_in >= b_in) ? (a_in - b_in) : (a_in - b_in + prime);
  assign acc_one = (prime == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign mag     = FIELD_W'(0) - FIELD_W'($unsigned(cmd.exponent));

  // command decode: which commands finish at once, which start a sequence
  always_comb begin
    imm        = 1'b1;
    imm_res    = '0;
    go_mul     = 1'b0;
    go_red     = 1'b0;
    launch_exp = XW'($unsigned(cmd.exponent));
    if (cmd.opcode == OP_POW) begin
      if (a_bad) begin
        imm_res.range_error = 1'b1;
      end else begin
        imm    = 1'b0;
        go_red = cmd.exponent[FIELD_W-1];
      end
    end else if (cmd.opcode != OP_ADD && cmd.opcode != OP_SUB && cmd.opcode != OP_MUL
                 && cmd.opcode != OP_DIV && cmd.opcode != OP_EQ && cmd.opcode != OP_NE) begin
      imm_res = '0;
    end else if (a_bad || b_bad) begin
      imm_res.range_error = 1'b1;
    end else begin
      unique case (cmd.opcode)
        OP_ADD: imm_res.value = FIELD_W'(add_v);
        OP_SUB: imm_res.value = FIELD_W'(sub_v);
        OP_EQ:  imm_res.value = FIELD_W'(a_in == b_in);
        OP_NE:  imm_res.value = FIELD_W'(a_in != b_in);
        OP_MUL: begin
          imm    = 1'b0;
          go_mul = 1'b1;
        end
        OP_DIV: begin
          if (b_in != '0) begin
            imm        = 1'b0;
            launch_exp = XW'(prime - WIDTH'(2));
          end
        end
        default: imm_res = '0;
      endcase
    end
  end

  assign red_go = start && !busy && go_red;

  always_comb begin
    case (state)
      S_SQ: begin
        mul_x = acc;
        mul_y = acc;
      end
      S_MULB: begin
        mul_x = acc;
        mul_y = base_r;
      end
      default: begin
        mul_x = a_r;
        mul_y = b_r;
      end
    endcase
  end

  // an exponent bit is finished: squaring with a clear bit, or the extra product
  assign adv = mul_done && ((state == S_SQ && !exp_r[XW-1]) || state == S_MULB);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      prime        <= RESET_PRIME[WIDTH-1:0];
      mul_start    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      mul_start    <= 1'b0;
      result_valid <= 1'b0;
      if (cfg_we) begin
        prime <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r   <= cmd.opcode;
            a_r    <= a_in;
            b_r    <= b_in;
            base_r <= (cmd.opcode == OP_POW) ? a_in : b_in;
            acc    <= acc_one;
            bitcnt <= CNT_TOP;
            exp_r  <= launch_exp;
            if (imm) begin
              result       <= imm_res;
              result_valid <= 1'b1;
            end else if (go_mul) begin
              state     <= S_FINAL;
              mul_start <= 1'b1;
            end else if (go_red) begin
              state <= S_RED;
            end else begin
              state     <= S_SQ;
              mul_start <= 1'b1;
            end
          end
        end
        S_RED: begin
          if (red_done) begin
            exp_r     <= red_e;
            state     <= S_SQ;
            mul_start <= 1'b1;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            acc <= mul_p;
            if (exp_r[XW-1]) begin
              state     <= S_MULB;
              mul_start <= 1'b1;
            end
          end
        end
        S_MULB: begin
          if (mul_done) begin
            acc <= mul_p;
          end
        end
        S_FINAL: begin
          if (mul_done) begin
            result.value       <= FIELD_W'(mul_p);
            result.range_error <= 1'b0;
            result_valid       <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (adv) begin
        if (bitcnt == '0) begin
          if (op_r == OP_DIV) begin
            b_r       <= mul_p;
            state     <= S_FINAL;
            mul_start <= 1'b1;
          end else begin
            result.value       <= FIELD_W'(mul_p);
            result.range_error <= 1'b0;
            result_valid       <= 1'b1;
            state              <= S_IDLE;
          end
        end else begin
          bitcnt    <= bitcnt - 1'b1;
          exp_r     <= exp_r << 1;
          state     <= S_SQ;
          mul_start <= 1'b1;
        end
      end
    end
  end

  pfa_modmul #(
    .WIDTH(WIDTH)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .x      (mul_x),
    .y      (mul_y),
    .m      (prime),
    .done   (mul_done),
    .product(mul_p)
  );

  pfa_expred #(
    .WIDTH(WIDTH)
  ) u_red (
    .clk    (clk),
    .rst    (rst),
    .start  (red_go),
    .mag    (mag),
    .m1     (prime - WIDTH'(1)),
    .done   (red_done),
    .exp_out(red_e)
  );

`ifndef SYNTHESIS
  // the multiplier only reports back to states that launched it
  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_SQ || state == S_MULB || state == S_FINAL))
    else $error("multiplier done outside a product state");

  a_red_owner: assert property (@(posedge clk) disable iff (rst)
    red_done |-> state == S_RED)
    else $error("exponent reduction done outside its state");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.range_error |-> result.value == '0)
    else $error("range error with nonzero value");

  a_add_one_cycle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd.opcode == OP_ADD |=> result_valid && !busy)
    else $error("add did not finish in one cycle");

  a_no_launch_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> state != S_IDLE)
    else $error("product launched while idle");
`endif

endmodule

// ===== sim/prime_field_alu_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_field_alu_test
// Self-checking bench for the prime field ALU: commands are sent with random
// idle gaps under several moduli, and every result is compared with a local
// model of the field arithmetic kept in a small scoreboard.
// ----------------------------------------------------------------------------
module prime_field_alu_test;
  import pfa_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
  localparam logic [31:0] MAX_PRIME32 = 32'hFFFF_FFFB;

  typedef struct packed {
    cmd_t cause;
    res_t want;
  } field_expect_t;

  class field_result_board;
    logic [63:0]   modulus;
    field_expect_t pending_q[$];
    int unsigned   noted;
    int unsigned   checked;
    int unsigned   mismatches;
    int unsigned   range_errs;

    function void set_modulus(logic [31:0] p);
      modulus = {32'b0, p};
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    // operands are below the modulus, so the product fits in 64 bits
    function logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y);
      return (x * y) % modulus;
    endfunction

    function logic [63:0] pow_mod(logic [63:0] base, logic [63:0] e);
      logic [63:0] acc;
      acc = 64'd1 % modulus;
      for (int i = 63; i >= 0; i--) begin
        acc = mul_mod(acc, acc);
        if (e[i]) acc = mul_mod(acc, base);
      end
      return acc;
    endfunction

    function res_t field_result(cmd_t c);
      logic [63:0] p, a, b, e, mag, m1, v;
      res_t r;
      p = modulus;
      a = {32'b0, c.operand_a};
      b = {32'b0, c.operand_b};
      v = '0;
      r = '0;
      if (c.opcode == OP_POW) begin
        if (a >= p) begin
          r.range_error = 1'b1;
        end else begin
          if (c.exponent[31]) begin
            // negative power: least nonnegative residue mod p-1
            mag = 64'h1_0000_0000 - {32'b0, c.exponent};
            m1  = p - 64'd1;
            e   = (m1 == 0) ? 64'd0 : (m1 - (mag % m1)) % m1;
          end else begin
            e = {32'b0, c.exponent};
          end
          v = pow_mod(a, e);
        end
      end else if (c.opcode != OP_UNUSED) begin
        if (a >= p || b >= p) begin
          r.range_error = 1'b1;
        end else begin
          case (c.opcode)
            OP_ADD: v = (a + b) % p;
            OP_SUB: v = (a >= b) ? a - b : p - (b - a);
            OP_MUL: v = mul_mod(a, b);
            OP_DIV: v = (b == 0) ? 64'd0 : mul_mod(a, pow_mod(b, p - 64'd2));
            OP_EQ:  v = (a == b) ? 64'd1 : 64'd0;
            default: v = (a != b) ? 64'd1 : 64'd0;
          endcase
        end
      end
      r.value = v[31:0];
      return r;
    endfunction

    function void note_command(cmd_t c);
      field_expect_t x;
      x.cause = c;
      x.want  = field_result(c);
      if (x.want.range_error) range_errs++;
      pending_q.push_back(x);
      noted++;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 30) $display("mismatch: %s", msg);
    endtask

    task check_result(res_t got);
      field_expect_t x;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing outstanding (value %h)",
                                  checked, got.value));
        return;
      end
      x = pending_q.pop_front();
      if (got.value !== x.want.value)
        report_mismatch($sformatf("result %0d op %0d a %h b %h e %h: value %h, want %h",
                                  checked, x.cause.opcode, x.cause.operand_a,
                                  x.cause.operand_b, x.cause.exponent,
                                  got.value, x.want.value));
      if (got.range_error !== x.want.range_error)
        report_mismatch($sformatf("result %0d op %0d a %h b %h: range_error %b, want %b",
                                  checked, x.cause.opcode, x.cause.operand_a,
                                  x.cause.operand_b, got.range_error,
                                  x.want.range_error));
      checked++;
    endtask

    task flush_leftovers();
      field_expect_t x;
      while (pending_q.size() != 0) begin
        x = pending_q.pop_front();
        report_mismatch($sformatf("no result for op %0d a %h b %h",
                                  x.cause.opcode, x.cause.operand_a, x.cause.operand_b));
      end
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             start;
  cmd_t             cmd;
  logic             busy;
  logic             cfg_we;
  logic [31:0]      cfg_data;
  logic             result_valid;
  res_t             result;

  field_result_board board;
  int unsigned       n_transfers;
  int unsigned       n_settings;

  prime_field_alu dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .cmd          (cmd),
    .busy         (busy),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("tb: failure");
    $finish;
  end

  // transfers and results are both sampled here, transfer first
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_command(cmd);
        n_transfers++;
      end
      if (result_valid !== 1'b0) board.check_result(result);
    end
  end

  function automatic cmd_t make_command(logic [OPCODE_W-1:0] op, logic [31:0] a,
                                        logic [31:0] b, logic signed [31:0] e);
    cmd_t c;
    c.opcode    = op;
    c.operand_a = a;
    c.operand_b = b;
    c.exponent  = e;
    return c;
  endfunction

  function automatic logic [31:0] random_element(logic [63:0] p);
    logic [63:0] v;
    case ($urandom_range(0, 15))
      0: v = 64'd0;
      1: v = 64'd1;
      2: v = p - 64'd1;
      3: v = p - 64'd2;
      4: v = p + ({32'b0, $urandom} % (64'h1_0000_0000 - p));   // out of range
      default: v = {32'b0, $urandom} % p;
    endcase
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] random_exponent();
    int v;
    case ($urandom_range(0, 7))
      0: return 32'sd0;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      3: return -32'sd1;
      4: begin
        v = $urandom_range(0, 40);
        return v - 20;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic cmd_t random_command(logic [63:0] p);
    cmd_t c;
    int unsigned r;
    r = $urandom_range(0, 31);
    if (r < 6) c.opcode = OP_ADD;
    else if (r < 11) c.opcode = OP_SUB;
    else if (r < 16) c.opcode = OP_MUL;
    else if (r < 20) c.opcode = OP_DIV;
    else if (r < 25) c.opcode = OP_POW;
    else if (r < 28) c.opcode = OP_EQ;
    else if (r < 31) c.opcode = OP_NE;
    else c.opcode = OP_UNUSED;
    c.operand_a = random_element(p);
    c.operand_b = random_element(p);
    if ((c.opcode == OP_EQ || c.opcode == OP_NE) && $urandom_range(0, 1))
      c.operand_b = c.operand_a;
    c.exponent = random_exponent();
    return c;
  endfunction

  // holds start high until the block takes the command; returns at a falling edge
  task automatic send_cmd(cmd_t c);
    int unsigned seen;
    seen = n_transfers;
    start <= 1'b1;
    cmd   <= c;
    do @(negedge clk); while (n_transfers == seen);
  endtask

  task automatic sender_pause(int pct);
    int n;
    n = 0;
    while ($urandom_range(0, 99) < pct) n++;
    if (pct > 0 && $urandom_range(0, 15) == 0) n += $urandom_range(1, 80);
    if (n > 0) begin
      start <= 1'b0;
      cmd   <= make_command(OPCODE_W'($urandom), $urandom, $urandom, $urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  // modulus is changed only once every outstanding result has come back
  task automatic write_modulus(logic [31:0] p);
    start <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= p;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= $urandom;
    board.set_modulus(p);
    n_settings++;
  endtask

  initial begin
    cmd_t        directed[$];
    logic [31:0] phase_mod[8];
    int          idle_mix[3];
    logic [31:0] pr;
    int          guard;

    board       = new();
    n_transfers = 0;
    n_settings  = 0;
    rst      = 1'b1;
    start    = 1'b0;
    cmd      = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    board.set_modulus(RESET_PRIME[31:0]);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field edges, each opcode, range errors, zero divisor, 0^0,
    // negative powers, and an unused opcode
    pr = RESET_PRIME[31:0];
    directed.push_back(make_command(OP_ADD, pr - 1, pr - 1, 0));
    directed.push_back(make_command(OP_ADD, 0, 0, -1));
    directed.push_back(make_command(OP_SUB, 0, pr - 1, 0));
    directed.push_back(make_command(OP_MUL, pr - 1, pr - 1, 0));
    directed.push_back(make_command(OP_DIV, 7, 0, 0));
    directed.push_back(make_command(OP_DIV, pr - 1, 3, 0));
    directed.push_back(make_command(OP_POW, 0, 0, 0));
    directed.push_back(make_command(OP_POW, 0, 5, -1));
    directed.push_back(make_command(OP_POW, 3, 0, 32'sh8000_0000));
    directed.push_back(make_command(OP_POW, pr - 1, 0, 32'sh7fff_ffff));
    directed.push_back(make_command(OP_POW, 2, 32'hFFFF_FFFF, -1));
    directed.push_back(make_command(OP_EQ, 5, 5, 0));
    directed.push_back(make_command(OP_NE, 5, 6, 0));
    directed.push_back(make_command(OP_EQ, 0, pr - 1, 0));
    directed.push_back(make_command(OP_ADD, pr, 0, 0));
    directed.push_back(make_command(OP_MUL, 1, 32'hFFFF_FFFF, 0));
    directed.push_back(make_command(OP_POW, 32'hFFFF_FFFF, 0, 2));
    directed.push_back(make_command(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1));
    directed.push_back(make_command(OP_DIV, 4, pr, 0));
    foreach (directed[i]) send_cmd(directed[i]);

    // degenerate moduli: 1 folds everything to 0, 0 rejects every operand
    write_modulus(32'd1);
    send_cmd(make_command(OP_ADD, 0, 0, 0));
    send_cmd(make_command(OP_POW, 0, 0, -5));
    send_cmd(make_command(OP_EQ, 0, 0, 0));
    send_cmd(make_command(OP_SUB, 1, 0, 0));
    write_modulus(32'd0);
    send_cmd(make_command(OP_ADD, 0, 0, 0));
    send_cmd(make_command(OP_POW, 0, 0, 0));

    phase_mod[0] = 32'd3;
    phase_mod[1] = MAX_PRIME32;
    phase_mod[2] = 32'hFFFF_FFFF;
    phase_mod[3] = 32'd65521;
    phase_mod[4] = 32'd251;
    phase_mod[5] = RESET_PRIME[31:0];
    phase_mod[6] = $urandom | 32'h8000_0001;
    phase_mod[7] = 32'd3;
    idle_mix[0] = 0;
    idle_mix[1] = 64;
    idle_mix[2] = 15;

    for (int ph = 0; ph < 8; ph++) begin
      write_modulus(phase_mod[ph]);
      for (int k = 0; k < 33; k++) begin
        sender_pause(idle_mix[ph % 3]);
        send_cmd(random_command({32'b0, phase_mod[ph]}));
      end
    end

    start <= 1'b0;
    guard = 0;
    while (board.pending() != 0 && guard < 10000) begin
      @(negedge clk);
      guard++;
    end
    // long enough for a stray result from the slowest operation
    repeat (2400) @(negedge clk);
    board.flush_leftovers();

    $display("summary: %0d commands, %0d results checked, %0d range errors, %0d moduli",
             board.noted, board.checked, board.range_errs, n_settings);
    $display("summary: all opcodes, moduli 0, 1, 3 up to 2^32-1, idle mixes 0/64/15 pct");
    if (board.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
